// ===== rtl/ppu_rvp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_rvp_pkg
// Shared types, codes and sizes for the video chip register and VRAM port.
// ----------------------------------------------------------------------------
package ppu_rvp_pkg;

  // Event codes carried in the operation field
  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_FRAME     = 3'd2,
    OP_LINE      = 3'd3,
    OP_VBL_START = 3'd4,
    OP_VBL_END   = 3'd5
  } ppu_op_t;

  // CPU-visible register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Configuration register numbers (byte address / 4)
  localparam logic CFG_NT_MAP = 1'b0;
  localparam logic CFG_WP     = 1'b1;

  localparam logic [7:0] NT_MAP_RESET = 8'h44;

  // Memory sizes
  localparam int PAT_DEPTH = 8192;
  localparam int PAT_AW    = $clog2(PAT_DEPTH);
  localparam int NT_DEPTH  = 4096;
  localparam int NT_AW     = $clog2(NT_DEPTH);
  localparam int SPR_DEPTH = 256;
  localparam int SPR_AW    = $clog2(SPR_DEPTH);

  // Memory access request from the register logic
  typedef struct packed {
    logic              pat_we;
    logic              pat_re;
    logic              nt_we;
    logic              nt_re;
    logic              spr_we;
    logic [PAT_AW-1:0] pat_addr;
    logic [NT_AW-1:0]  nt_addr;
    logic [SPR_AW-1:0] spr_addr;
    logic [7:0]        wdata;
  } vram_req_t;

endpackage

// ===== rtl/ppu_register_and_vram_port_unit.sv =====
// ----------------------------------------------------------------------------
// ppu_register_and_vram_port_unit
// CPU-side register and video-memory port of a tile video chip.
// ----------------------------------------------------------------------------
// Each input beat is one event (register read or write, frame start, scanline,
// vblank start or end) and yields exactly one result byte, zero for anything
// but a read. One event is taken every cycle: the event is decoded and all
// state, including the one memory word it touches, is updated at the edge it
// is accepted, and its result goes into a two-entry output buffer, so input
// stalls only when two results are waiting or while memories are cleared.
// Data-port reads of pattern or nametable memory land in the memory read
// registers, which serve as the read buffer for the next such read. After
// reset a clearing pass zeroes the memories, during which no event is accepted;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module ppu_register_and_vram_port_unit (
  input  logic        clk,
  input  logic        rst,
  // Events
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] write_data
  input  logic [5:0]  s_tuser,   // [2:0] operation, [5:3] reg_index
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] read_data
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ppu_rvp_pkg::*;

  logic       nametable_map;
  logic [7:0] nt_map;
  logic       wp;
  logic       accept;
  logic       obuf_full;
  logic       vram_busy;
  logic [7:0] read_buffer;
  logic [7:0] read_data;
  vram_req_t  req;

  // Configuration registers
  assign pready = 1'b1;
  assign nametable_map = (paddr[2] == CFG_NT_MAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      nt_map <= NT_MAP_RESET;
      wp     <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (nametable_map) begin
        nt_map <= pwdata[7:0];
      end else begin
        wp <= pwdata[0];
      end
    end
  end

  assign prdata = nametable_map ? {24'h0, nt_map} : {31'h0, wp};

  // Take an event whenever a result slot is free and memory is ready
  assign s_tready = !obuf_full && !vram_busy;
  assign accept   = s_tvalid && s_tready;

  ppu_rvp_ctrl u_ctrl (
    .clk                   (clk),
    .rst                   (rst),
    .accept                (accept),
    .operation             (s_tuser[2:0]),
    .reg_index             (s_tuser[5:3]),
    .write_data            (s_tdata),
    .nametable_map         (nt_map),
    .pattern_write_protect (wp),
    .read_buffer           (read_buffer),
    .req                   (req),
    .read_data             (read_data)
  );

  ppu_rvp_vram u_vram (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .busy        (vram_busy),
    .read_buffer (read_buffer)
  );

  ppu_rvp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (read_data),
    .full      (obuf_full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== rtl/ppu_rvp_vram.sv =====
// ----------------------------------------------------------------------------
// ppu_rvp_vram
// Pattern, nametable and sprite memories with a clearing pass after reset,
// and the one-byte read buffer of the data port, held in the read registers.
// ----------------------------------------------------------------------------
module ppu_rvp_vram (
  input  logic                  clk,
  input  logic                  rst,
  input  ppu_rvp_pkg::vram_req_t req,
  output logic                  busy,
  output logic [7:0]            read_buffer
);
  import ppu_rvp_pkg::*;

  logic [7:0] pat_mem [PAT_DEPTH];
  logic [7:0] nt_mem  [NT_DEPTH];
  logic [7:0] spr_mem [SPR_DEPTH];

  logic [PAT_AW-1:0] clr_cnt;
  logic              clearing;
  logic [7:0]        pat_q;
  logic [7:0]        nt_q;
  logic              buf_valid;
  logic              buf_from_nt;

  // Sweep every pattern address once after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == {PAT_AW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing;

  // Pattern memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      pat_mem[clr_cnt] <= 8'h00;
    end else if (req.pat_we) begin
      pat_mem[req.pat_addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.pat_re) begin
      pat_q <= pat_mem[req.pat_addr];
    end
  end

  // Nametable memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      nt_mem[clr_cnt[NT_AW-1:0]] <= 8'h00;
    end else if (req.nt_we) begin
      nt_mem[req.nt_addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.nt_re) begin
      nt_q <= nt_mem[req.nt_addr];
    end
  end

  // Sprite memory, held for the renderer
  always_ff @(posedge clk) begin
    if (clearing) begin
      spr_mem[clr_cnt[SPR_AW-1:0]] <= 8'h00;
    end else if (req.spr_we) begin
      spr_mem[req.spr_addr] <= req.wdata;
    end
  end

  // Track which read register holds the buffered byte
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid   <= 1'b0;
      buf_from_nt <= 1'b0;
    end else if (req.pat_re || req.nt_re) begin
      buf_valid   <= 1'b1;
      buf_from_nt <= req.nt_re;
    end
  end

  always_comb begin
    if (!buf_valid) begin
      read_buffer = 8'h00;
    end else if (buf_from_nt) begin
      read_buffer = nt_q;
    end else begin
      read_buffer = pat_q;
    end
  end

endmodule

// ===== rtl/ppu_rvp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppu_rvp_ctrl
// Register bytes, scroll latches, write toggle, sprite pointer and palettes.
// Decodes one event per beat and issues at most one memory access.
// ----------------------------------------------------------------------------
module ppu_rvp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [2:0]             operation,
  input  logic [2:0]             reg_index,
  input  logic [7:0]             write_data,
  input  logic [7:0]             nametable_map,
  input  logic                   pattern_write_protect,
  input  logic [7:0]             read_buffer,
  output ppu_rvp_pkg::vram_req_t req,
  output logic [7:0]             read_data
);
  import ppu_rvp_pkg::*;

  localparam logic [15:0] SCROLL_X_KEEP = 16'hFBE0;
  localparam logic [14:0] SCROLL_X_TAKE = 15'h041F;
  localparam logic [15:0] FINE_Y_CLEAR  = 16'h8FFF;
  localparam logic [15:0] COARSE_Y_CLR  = 16'hFC1F;
  localparam logic [15:0] NT_V_FLIP     = 16'h0800;
  localparam logic [15:0] ROW_STEP      = 16'h0020;
  localparam logic [15:0] FINE_Y_STEP   = 16'h1000;
  localparam logic [4:0]  COARSE_Y_LAST = 5'd29;
  localparam logic [4:0]  COARSE_Y_MAX  = 5'd31;
  localparam logic [5:0]  PAL_PAGE      = 6'h3F;

  logic [7:0]  regs [8];
  logic [14:0] temp_address;
  logic [15:0] current_address;
  logic [2:0]  fine_x;
  logic        write_toggle;
  logic        increment_by_row;
  logic [7:0]  sprite_pointer;
  logic [5:0]  bg_pal  [16];
  logic [5:0]  spr_pal [16];

  logic [7:0]  regs_next [8];
  logic [14:0] temp_next;
  logic [15:0] current_next;
  logic [2:0]  fine_x_next;
  logic        toggle_next;
  logic        inc_row_next;
  logic [7:0]  sprite_pointer_next;
  logic        bg_we, spr_we_pal;
  logic [3:0]  pal_idx;
  logic [5:0]  pal_d;

  logic [13:0] port_addr;
  logic        is_pal;
  logic        is_pat;
  logic [7:0]  map_shift;
  logic [15:0] bumped;
  logic        rendering;
  logic [15:0] v;

  // Data-port address decode
  assign port_addr = current_address[13:0];
  assign is_pal    = (port_addr[13:8] == PAL_PAGE);
  assign is_pat    = !port_addr[13];
  assign map_shift = nametable_map >> {port_addr[11:10], 1'b0};
  assign bumped    = current_address + (increment_by_row ? 16'd32 : 16'd1);
  assign rendering = (regs[REG_MASK][4:3] != 2'b00);

  // Decode one event
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      regs_next[i] = regs[i];
    end
    temp_next           = temp_address;
    current_next        = current_address;
    fine_x_next         = fine_x;
    toggle_next         = write_toggle;
    inc_row_next        = increment_by_row;
    sprite_pointer_next = sprite_pointer;
    bg_we               = 1'b0;
    spr_we_pal          = 1'b0;
    pal_idx             = port_addr[3:0];
    pal_d               = write_data[5:0];
    read_data           = 8'h00;
    v                   = '0;
    req                 = '0;
    req.pat_addr        = port_addr[PAT_AW-1:0];
    req.nt_addr         = {map_shift[1:0], port_addr[9:0]};
    req.spr_addr        = sprite_pointer;
    req.wdata           = write_data;

    unique case (operation)
      OP_READ: begin
        unique case (reg_index)
          REG_STATUS: begin
            read_data               = regs[REG_STATUS];
            regs_next[REG_STATUS][7] = 1'b0;
            toggle_next             = 1'b0;
          end
          REG_DATA: begin
            current_next = bumped;
            if (is_pal) begin
              read_data = {2'b00, port_addr[4] ? spr_pal[port_addr[3:0]]
                                               : bg_pal[port_addr[3:0]]};
            end else begin
              read_data  = read_buffer;
              req.pat_re = is_pat;
              req.nt_re  = !is_pat;
            end
          end
          default: begin
            read_data = regs[reg_index];
          end
        endcase
      end
      OP_WRITE: begin
        regs_next[reg_index] = write_data;
        unique case (reg_index)
          REG_CTRL: begin
            inc_row_next     = write_data[2];
            temp_next[11:10] = write_data[1:0];
          end
          REG_OAM_ADDR: begin
            sprite_pointer_next = write_data;
          end
          REG_OAM_DATA: begin
            req.spr_we          = 1'b1;
            sprite_pointer_next = sprite_pointer + 8'd1;
          end
          REG_SCROLL: begin
            toggle_next = !write_toggle;
            if (!write_toggle) begin
              temp_next[4:0] = write_data[7:3];
              fine_x_next    = write_data[2:0];
            end else begin
              temp_next[9:5]   = write_data[7:3];
              temp_next[14:12] = write_data[2:0];
            end
          end
          REG_ADDR: begin
            toggle_next = !write_toggle;
            if (!write_toggle) begin
              temp_next[14:8] = {1'b0, write_data[5:0]};
            end else begin
              temp_next[7:0] = write_data;
              current_next   = {1'b0, temp_address[14:8], write_data};
            end
          end
          REG_DATA: begin
            current_next = bumped;
            if (is_pal) begin
              if (port_addr[3:0] == 4'h0) begin
                bg_we      = 1'b1;
                spr_we_pal = 1'b1;
              end else begin
                bg_we      = !port_addr[4];
                spr_we_pal = port_addr[4];
              end
            end else if (is_pat) begin
              req.pat_we = !pattern_write_protect;
            end else begin
              req.nt_we = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      OP_FRAME: begin
        if (rendering) begin
          current_next = {1'b0, temp_address};
        end
      end
      OP_LINE: begin
        if (rendering) begin
          // Reload horizontal scroll, then step down one pixel row
          v = (current_address & SCROLL_X_KEEP) | {1'b0, temp_address & SCROLL_X_TAKE};
          if (v[14:12] == 3'b111) begin
            v = v & FINE_Y_CLEAR;
            if (v[9:5] == COARSE_Y_LAST) begin
              v = (v ^ NT_V_FLIP) & COARSE_Y_CLR;
            end else if (v[9:5] == COARSE_Y_MAX) begin
              v = v & COARSE_Y_CLR;
            end else begin
              v = v + ROW_STEP;
            end
          end else begin
            v = v + FINE_Y_STEP;
          end
          current_next = v;
        end
      end
      OP_VBL_START: begin
        regs_next[REG_STATUS][7] = 1'b1;
      end
      OP_VBL_END: begin
        regs_next[REG_STATUS][7:6] = 2'b00;
      end
      default: begin
      end
    endcase

    if (!accept) begin
      req.pat_we = 1'b0;
      req.pat_re = 1'b0;
      req.nt_we  = 1'b0;
      req.nt_re  = 1'b0;
      req.spr_we = 1'b0;
    end
  end

  // Update state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= 8'h00;
      end
      for (int i = 0; i < 16; i++) begin
        bg_pal[i]  <= 6'h00;
        spr_pal[i] <= 6'h00;
      end
      temp_address     <= '0;
      current_address  <= '0;
      fine_x           <= '0;
      write_toggle     <= 1'b0;
      increment_by_row <= 1'b0;
      sprite_pointer   <= '0;
    end else if (accept) begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= regs_next[i];
      end
      if (bg_we) begin
        bg_pal[pal_idx] <= pal_d;
      end
      if (spr_we_pal) begin
        spr_pal[pal_idx] <= pal_d;
      end
      temp_address     <= temp_next;
      current_address  <= current_next;
      fine_x           <= fine_x_next;
      write_toggle     <= toggle_next;
      increment_by_row <= inc_row_next;
      sprite_pointer   <= sprite_pointer_next;
    end
  end

endmodule

// ===== rtl/ppu_rvp_obuf.sv =====
// ----------------------------------------------------------------------------
// ppu_rvp_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module ppu_rvp_obuf (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  output logic       full,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata
);

  logic       v0, v1;
  logic [7:0] d0, d1;
  logic       pop;

  assign pop      = v0 && m_tready;
  assign full     = v1;
  assign m_tvalid = v0;
  assign m_tdata  = d0;

  // Advance the head, fill the first free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      case ({push, pop})
        2'b01: begin
          v0 <= v1;
          v1 <= 1'b0;
        end
        2'b10: begin
          if (!v0) begin
            v0 <= 1'b1;
          end else begin
            v1 <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b01: begin
        d0 <= d1;
      end
      2'b10: begin
        if (!v0) begin
          d0 <= push_data;
        end else begin
          d1 <= push_data;
        end
      end
      2'b11: begin
        if (v1) begin
          d0 <= d1;
          d1 <= push_data;
        end else begin
          d0 <= push_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
